@@ hw/rtl/lpi_pkg.sv @@
// Shared widths, reset values and sideband types of the lead intercept core.
package lpi_pkg;

	localparam int IN_W       = 32;
	localparam int SPD_W      = 31;
	localparam int THR_W      = 32;
	localparam logic [THR_W-1:0] THR_RST = 32'd4295;
	localparam int Q_W        = 31;
	localparam int FRAC_W     = 16;
	localparam int LIMB_W     = 32;

	localparam int S_TDATA_W  = 320;
	localparam int M_TDATA_W  = 128;

	localparam int MUL_W      = 33;
	localparam int A_W        = 66;
	localparam int B_W        = 68;
	localparam int C_W        = 66;
	localparam int ABSA_W     = 64;
	localparam int ABSB_W     = 66;
	localparam int DEN_W      = 66;
	localparam int SQR_W      = 66;
	localparam int DISC_W     = 134;
	localparam int SQX_W      = 164;
	localparam int ROOT_W     = SQX_W / 2;
	localparam int N_W        = 85;
	localparam int NUM_W      = 84;
	localparam int SUM_W      = 49;

	typedef struct packed {
		logic [2:0][IN_W-1:0] tgt;
		logic [2:0][IN_W-1:0] vel;
	} geo_t;

	typedef struct packed {
		geo_t       geo;
		logic [2:0] dvneg;
	} sd1_t;

	typedef struct packed {
		geo_t              geo;
		logic              bneg;
		logic [ABSB_W-1:0] absb;
		logic              aneg;
		logic [DEN_W-1:0]  absa2;
		logic [C_W-1:0]    c;
		logic              lin;
		logic              anz;
	} sd2_t;

	typedef struct packed {
		sd2_t coef;
		logic dok;
		logic lin_ok;
	} sd3_t;

	typedef struct packed {
		geo_t geo;
		logic have;
	} sd4_t;

	typedef struct packed {
		geo_t           geo;
		logic [Q_W-1:0] t;
	} sd5_t;

endpackage

@@ hw/rtl/projectile_lead_intercept_core.sv @@
// Lead intercept core: quadratic time-to-intercept solver and aim point, fully pipelined.
// Each request (shooter, target, target velocity, projectile speed, all Q16.16) yields one
// result: the aim point target + v*t saturated to Q16.16, a found flag on m_tuser and the
// intercept time t. A request is taken every cycle unless the output stalls. The latency
// is set mostly by the 82-stage square root of the discriminant and the 31-stage quotient
// divider. The whole pipeline advances together and holds while a result waits on m_tready.
// The degenerate threshold (Q0.32, reset 4295) is written through cfg_we/cfg_wdata; the user
// must write it only while no request is in flight, as the block does not enforce this.
module projectile_lead_intercept_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lpi_pkg::THR_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// shooter_x, shooter_y, shooter_z, target_x, target_y, target_z, vel_x, vel_y, vel_z,
	// projectile_speed, zero pad
	input  logic [lpi_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// lead_x, lead_y, lead_z, intercept_time, zero pad
	output logic [lpi_pkg::M_TDATA_W-1:0]  m_tdata,
	// intercept_found
	output logic                           m_tuser
);
	import lpi_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic             ce;

	// intake
	logic [IN_W-1:0]     sh [3];
	logic [IN_W-1:0]     tg [3];
	logic [IN_W-1:0]     vl [3];
	logic [IN_W:0]       dfull [3];
	logic [MUL_W-1:0]    dmag [3];
	logic [IN_W-1:0]     vmag [3];

	logic                vld_s1;
	logic [MUL_W-1:0]    dmag_s1 [3];
	logic [IN_W-1:0]     vmag_s1 [3];
	logic [SPD_W-1:0]    spd_s1;
	sd1_t                sd1_s1;

	logic [MUL_W-1:0]    m1_a [10];
	logic [MUL_W-1:0]    m1_b [10];
	logic [2*MUL_W-1:0]  p1 [10];
	logic                vld_m1;
	sd1_t                sd1_m1;

	// coefficient sums
	logic                vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic signed [A_W-1:0] a01_s5, a2s_s5, a_s6, a_s7;
	logic signed [B_W-1:0] dvs_s5 [3];
	logic signed [B_W-1:0] b01_s6, b2_s6, b_s7;
	logic [C_W-1:0]      c01_s5, c2_s5, c_s6, c_s7;
	logic [ABSA_W-1:0]   absa_s7, absa_s8;
	geo_t                geo_s5, geo_s6, geo_s7;
	logic [ABSB_W-1:0]   absb_s8;
	sd2_t                sd2_s8;

	logic [SQR_W-1:0]    m2_a [2];
	logic [SQR_W-1:0]    m2_b [2];
	logic [2*SQR_W-1:0]  p2 [2];
	logic                vld_m2;
	sd2_t                sd2_m2;

	logic signed [DISC_W-1:0] disc_s9;
	sd2_t                sd2_s9;
	logic                lin_ok_s9;
	sd3_t                sd3_in;
	logic [SQX_W-1:0]    sq_x;

	// roots
	logic                vld_sq;
	logic [ROOT_W-1:0]   root_sq;
	sd3_t                sd3_sq;
	logic                vld_s10, vld_s11, vld_s12, vld_s13;
	logic signed [N_W-1:0] nb, nb_s10, n0_s11, n1_s11, pick_s12, first_n, second_n, absp;
	logic [ROOT_W-1:0]   r_s10;
	sd3_t                sd3_s10, sd3_s11, sd3_s12;
	logic                dneg, pos_first, pos_second;
	logic                qhave_s12;
	logic [NUM_W-1:0]    num_s13;
	logic [DEN_W-1:0]    den_s13;
	sd4_t                sd4_s13;

	logic                vld_dv;
	logic [Q_W-1:0]      q_dv;
	sd4_t                sd4_dv;

	// aim point
	logic                vld_s14;
	logic [Q_W-1:0]      t_s14;
	logic [IN_W-1:0]     vmag_s14 [3];
	sd5_t                sd5_s14;
	logic [IN_W-1:0]     m3_a [3];
	logic [Q_W-1:0]      m3_b [3];
	logic [IN_W+Q_W-1:0] p3 [3];
	logic                vld_m3;
	sd5_t                sd5_m3;

	logic                vld_s15, vld_s16;
	logic signed [2*IN_W-1:0] sp_s15 [3];
	sd5_t                sd5_s15, sd5_s16;
	logic signed [SUM_W-1:0]  sum_s16 [3];
	logic [IN_W-1:0]     sat [3];

	logic                vld_q;
	logic [IN_W-1:0]     lead_q [3];
	logic [Q_W-1:0]      time_q;
	logic                found_q;

	assign ce       = !vld_q || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			thr_q <= THR_RST;
		else if (cfg_we)
			thr_q <= cfg_wdata;
	end

	// ---------------- intake: offset and magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i]    = s_tdata[IN_W*i +: IN_W];
			tg[i]    = s_tdata[IN_W*(3+i) +: IN_W];
			vl[i]    = s_tdata[IN_W*(6+i) +: IN_W];
			dfull[i] = {tg[i][IN_W-1], tg[i]} - {sh[i][IN_W-1], sh[i]};
			dmag[i]  = dfull[i][IN_W] ? -dfull[i] : dfull[i];
			vmag[i]  = vl[i][IN_W-1] ? -vl[i] : vl[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				dmag_s1[i]         <= dmag[i];
				vmag_s1[i]         <= vmag[i];
				sd1_s1.geo.tgt[i]  <= tg[i];
				sd1_s1.geo.vel[i]  <= vl[i];
				sd1_s1.dvneg[i]    <= dfull[i][IN_W] ^ vl[i][IN_W-1];
			end
			spd_s1 <= s_tdata[IN_W*9 +: SPD_W];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m1_a[i]   = MUL_W'(vmag_s1[i]);
			m1_b[i]   = MUL_W'(vmag_s1[i]);
			m1_a[4+i] = dmag_s1[i];
			m1_b[4+i] = MUL_W'(vmag_s1[i]);
			m1_a[7+i] = dmag_s1[i];
			m1_b[7+i] = dmag_s1[i];
		end
		m1_a[3] = MUL_W'(spd_s1);
		m1_b[3] = MUL_W'(spd_s1);
	end

	lpi_mul #(
		.LANES(10), .AW(MUL_W), .BW(MUL_W), .SW($bits(sd1_t))
	) u_mul_coef (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(vld_s1),
		.a(m1_a), .b(m1_b), .in_side(sd1_s1),
		.out_vld(vld_m1), .prod(p1), .out_side(sd1_m1)
	);

	// ---------------- a = v.v - s^2, b = 2 d.v, c = d.d
	always_ff @(posedge clk) begin
		if (ce) begin
			a01_s5 <= $signed(A_W'(p1[0])) + $signed(A_W'(p1[1]));
			a2s_s5 <= $signed(A_W'(p1[2])) - $signed(A_W'(p1[3]));
			for (int i = 0; i < 3; i++)
				dvs_s5[i] <= sd1_m1.dvneg[i] ? -$signed(B_W'(p1[4+i]))
					: $signed(B_W'(p1[4+i]));
			c01_s5 <= C_W'(p1[7]) + C_W'(p1[8]);
			c2_s5  <= C_W'(p1[9]);
			geo_s5 <= sd1_m1.geo;

			a_s6   <= a01_s5 + a2s_s5;
			b01_s6 <= dvs_s5[0] + dvs_s5[1];
			b2_s6  <= dvs_s5[2];
			c_s6   <= c01_s5 + c2_s5;
			geo_s6 <= geo_s5;

			b_s7    <= (b01_s6 + b2_s6) <<< 1;
			a_s7    <= a_s6;
			absa_s7 <= ABSA_W'(a_s6[A_W-1] ? -a_s6 : a_s6);
			c_s7    <= c_s6;
			geo_s7  <= geo_s6;

			absb_s8      <= ABSB_W'(b_s7[B_W-1] ? -b_s7 : b_s7);
			absa_s8      <= absa_s7;
			sd2_s8.geo   <= geo_s7;
			sd2_s8.bneg  <= b_s7[B_W-1];
			sd2_s8.absb  <= ABSB_W'(b_s7[B_W-1] ? -b_s7 : b_s7);
			sd2_s8.aneg  <= a_s7[A_W-1];
			sd2_s8.absa2 <= DEN_W'({absa_s7, 1'b0});
			sd2_s8.c     <= c_s7;
			sd2_s8.lin   <= absa_s7 < ABSA_W'(thr_q);
			sd2_s8.anz   <= a_s7 != '0;
		end
	end

	assign m2_a[0] = SQR_W'(absb_s8);
	assign m2_b[0] = SQR_W'(absb_s8);
	assign m2_a[1] = SQR_W'(absa_s8);
	assign m2_b[1] = SQR_W'(sd2_s8.c);

	lpi_mul #(
		.LANES(2), .AW(SQR_W), .BW(SQR_W), .SW($bits(sd2_t))
	) u_mul_disc (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(vld_s8),
		.a(m2_a), .b(m2_b), .in_side(sd2_s8),
		.out_vld(vld_m2), .prod(p2), .out_side(sd2_m2)
	);

	// ---------------- discriminant b^2 - 4ac
	always_ff @(posedge clk) begin
		if (ce) begin
			disc_s9 <= sd2_m2.aneg
				? $signed(DISC_W'(p2[0])) + $signed(DISC_W'(p2[1]) << 2)
				: $signed(DISC_W'(p2[0])) - $signed(DISC_W'(p2[1]) << 2);
			sd2_s9    <= sd2_m2;
			lin_ok_s9 <= sd2_m2.bneg && (sd2_m2.absb > ABSB_W'(thr_q)) && (sd2_m2.c != '0);
		end
	end

	assign sd3_in.coef   = sd2_s9;
	assign sd3_in.dok    = !disc_s9[DISC_W-1];
	assign sd3_in.lin_ok = lin_ok_s9;
	// root of disc * 2^32 is the Q.48 root of the discriminant
	assign sq_x = SQX_W'(disc_s9) << (2 * FRAC_W);

	lpi_isqrt #(
		.XW(SQX_W), .SW($bits(sd3_t))
	) u_isqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(vld_s9),
		.x(sq_x), .in_side(sd3_in),
		.out_vld(vld_sq), .root(root_sq), .out_side(sd3_sq)
	);

	// ---------------- root numerators and choice of the smallest positive time
	always_comb begin
		nb = $signed(N_W'(sd3_sq.coef.absb) << FRAC_W);
		if (!sd3_sq.coef.bneg)
			nb = -nb;
	end

	always_comb begin
		dneg       = sd3_s11.coef.aneg;
		first_n    = dneg ? n1_s11 : n0_s11;
		second_n   = dneg ? n0_s11 : n1_s11;
		pos_first  = (first_n != '0) && (first_n[N_W-1] == dneg);
		pos_second = (second_n != '0) && (second_n[N_W-1] == dneg);
		absp       = pick_s12[N_W-1] ? -pick_s12 : pick_s12;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			nb_s10  <= nb;
			r_s10   <= root_sq;
			sd3_s10 <= sd3_sq;

			n0_s11  <= nb_s10 - $signed(N_W'(r_s10));
			n1_s11  <= nb_s10 + $signed(N_W'(r_s10));
			sd3_s11 <= sd3_s10;

			pick_s12  <= pos_first ? first_n : second_n;
			qhave_s12 <= sd3_s11.dok && sd3_s11.coef.anz && (pos_first || pos_second);
			sd3_s12   <= sd3_s11;

			if (sd3_s12.coef.lin) begin
				num_s13      <= NUM_W'(sd3_s12.coef.c) << FRAC_W;
				den_s13      <= DEN_W'(sd3_s12.coef.absb);
				sd4_s13.have <= sd3_s12.lin_ok;
			end else begin
				num_s13      <= NUM_W'(absp);
				den_s13      <= sd3_s12.coef.absa2;
				sd4_s13.have <= qhave_s12;
			end
			sd4_s13.geo <= sd3_s12.coef.geo;
		end
	end

	lpi_div #(
		.NW(NUM_W), .DW(DEN_W), .QW(Q_W), .SW($bits(sd4_t))
	) u_div (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(vld_s13),
		.num(num_s13), .den(den_s13), .in_side(sd4_s13),
		.out_vld(vld_dv), .quot(q_dv), .out_side(sd4_dv)
	);

	// ---------------- aim point target + floor(v*t / 2^16), saturated
	always_ff @(posedge clk) begin
		if (ce) begin
			t_s14       <= sd4_dv.have ? q_dv : '0;
			sd5_s14.geo <= sd4_dv.geo;
			sd5_s14.t   <= sd4_dv.have ? q_dv : '0;
			for (int i = 0; i < 3; i++)
				vmag_s14[i] <= sd4_dv.geo.vel[i][IN_W-1] ? -sd4_dv.geo.vel[i]
					: sd4_dv.geo.vel[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m3_a[i] = vmag_s14[i];
			m3_b[i] = t_s14;
		end
	end

	lpi_mul #(
		.LANES(3), .AW(IN_W), .BW(Q_W), .SW($bits(sd5_t))
	) u_mul_lead (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(vld_s14),
		.a(m3_a), .b(m3_b), .in_side(sd5_s14),
		.out_vld(vld_m3), .prod(p3), .out_side(sd5_m3)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// clamp to the signed 32-bit range when the upper bits disagree
			if (sum_s16[i][SUM_W-1:IN_W-1] == '0 || sum_s16[i][SUM_W-1:IN_W-1] == '1)
				sat[i] = sum_s16[i][IN_W-1:0];
			else
				sat[i] = sum_s16[i][SUM_W-1] ? {1'b1, {(IN_W-1){1'b0}}}
					: {1'b0, {(IN_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				sp_s15[i] <= sd5_m3.geo.vel[i][IN_W-1]
					? -$signed((2*IN_W)'(p3[i])) : $signed((2*IN_W)'(p3[i]));
				sum_s16[i] <= $signed(SUM_W'($signed(sd5_s15.geo.tgt[i])))
					+ $signed(SUM_W'(sp_s15[i] >>> FRAC_W));
				lead_q[i] <= sat[i];
			end
			sd5_s15 <= sd5_m3;
			sd5_s16 <= sd5_s15;
			time_q  <= sd5_s16.t;
			found_q <= sd5_s16.t != '0;
		end
	end

	// ---------------- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
			vld_q   <= 1'b0;
		end else if (ce) begin
			vld_s1  <= s_tvalid;
			vld_s5  <= vld_m1;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_m2;
			vld_s10 <= vld_sq;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_dv;
			vld_s15 <= vld_m3;
			vld_s16 <= vld_s15;
			vld_q   <= vld_s16;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {1'b0, time_q, lead_q[2], lead_q[1], lead_q[0]};
	assign m_tuser  = found_q;

endmodule

@@ hw/rtl/lpi_mul.sv @@
// Multi-lane unsigned multiplier in three stages: limb products, row sums, final sum.
module lpi_mul #(
	parameter int LANES = 1,
	parameter int AW    = 32,
	parameter int BW    = 32,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_vld,
	input  logic [AW-1:0] a [LANES],
	input  logic [BW-1:0] b [LANES],
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [AW+BW-1:0] prod [LANES],
	output logic [SW-1:0] out_side
);
	import lpi_pkg::*;

	localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
	localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
	localparam int AP = NA * LIMB_W;
	localparam int BP = NB * LIMB_W;
	localparam int PW = AW + BW;

	logic [AP-1:0]         a_pad [LANES];
	logic [BP-1:0]         b_pad [LANES];
	logic [2*LIMB_W-1:0]   pp_s1 [LANES][NA][NB];
	logic [PW-1:0]         row_d [LANES][NA];
	logic [PW-1:0]         row_s2 [LANES][NA];
	logic [PW-1:0]         prod_d [LANES];
	logic [PW-1:0]         prod_s3 [LANES];
	logic [SW-1:0]         side_s1, side_s2, side_s3;
	logic                  vld_s1, vld_s2, vld_s3;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			a_pad[l] = AP'(a[l]);
			b_pad[l] = BP'(b[l]);
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			for (int i = 0; i < NA; i++) begin
				row_d[l][i] = '0;
				for (int j = 0; j < NB; j++)
					row_d[l][i] = row_d[l][i] + (PW'(pp_s1[l][i][j]) << (LIMB_W * j));
			end
			prod_d[l] = '0;
			for (int i = 0; i < NA; i++)
				prod_d[l] = prod_d[l] + (row_s2[l][i] << (LIMB_W * i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ce) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int l = 0; l < LANES; l++) begin
				for (int i = 0; i < NA; i++) begin
					for (int j = 0; j < NB; j++)
						pp_s1[l][i][j] <= a_pad[l][LIMB_W*i +: LIMB_W]
							* b_pad[l][LIMB_W*j +: LIMB_W];
					row_s2[l][i] <= row_d[l][i];
				end
				prod_s3[l] <= prod_d[l];
			end
			side_s1 <= in_side;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign prod     = prod_s3;
	assign out_side = side_s3;

endmodule

@@ hw/rtl/lpi_isqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module lpi_isqrt #(
	parameter int XW = 164,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_vld,
	input  logic [XW-1:0] x,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [XW/2-1:0] root,
	output logic [SW-1:0] out_side
);
	localparam int RW  = XW / 2;
	localparam int RMW = RW + 2;

	logic [RMW-1:0] rem_sn  [RW];
	logic [RW-1:0]  root_sn [RW];
	logic [XW-1:0]  x_sn    [RW];
	logic [SW-1:0]  side_sn [RW];
	logic           vld_sn  [RW];

	logic [RMW-1:0] rem_in  [RW];
	logic [RW-1:0]  root_in [RW];
	logic [XW-1:0]  x_in    [RW];
	logic [SW-1:0]  side_in [RW];
	logic           vld_in  [RW];
	logic [RMW-1:0] rem_sh  [RW];
	logic [RMW-1:0] trial   [RW];
	logic           take    [RW];

	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		x_in[0]    = x;
		side_in[0] = in_side;
		vld_in[0]  = in_vld;
		for (int k = 1; k < RW; k++) begin
			rem_in[k]  = rem_sn[k-1];
			root_in[k] = root_sn[k-1];
			x_in[k]    = x_sn[k-1];
			side_in[k] = side_sn[k-1];
			vld_in[k]  = vld_sn[k-1];
		end
		for (int k = 0; k < RW; k++) begin
			// bring down the next two radicand bits, try root*4+1
			rem_sh[k] = {rem_in[k][RW-1:0], x_in[k][XW-1 -: 2]};
			trial[k]  = {root_in[k], 2'b01};
			take[k]   = rem_sh[k] >= trial[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RW; k++)
				vld_sn[k] <= 1'b0;
		end else if (ce) begin
			for (int k = 0; k < RW; k++)
				vld_sn[k] <= vld_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < RW; k++) begin
				rem_sn[k]  <= take[k] ? rem_sh[k] - trial[k] : rem_sh[k];
				root_sn[k] <= {root_in[k][RW-2:0], take[k]};
				x_sn[k]    <= {x_in[k][XW-3:0], 2'b00};
				side_sn[k] <= side_in[k];
			end
		end
	end

	assign out_vld  = vld_sn[RW-1];
	assign root     = root_sn[RW-1];
	assign out_side = side_sn[RW-1];

endmodule

@@ hw/rtl/lpi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; quotient saturates at all ones.
module lpi_div #(
	parameter int NW = 84,
	parameter int DW = 66,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] out_side
);
	// compare width; holds both the remainder and the shifted divisor
	localparam int CW = (DW + QW > NW) ? DW + QW : NW;

	logic [NW-1:0] rem_sn  [QW];
	logic [DW-1:0] den_sn  [QW];
	logic [QW-1:0] q_sn    [QW];
	logic [SW-1:0] side_sn [QW];
	logic          vld_sn  [QW];

	logic [NW-1:0] rem_in  [QW];
	logic [DW-1:0] den_in  [QW];
	logic [QW-1:0] q_in    [QW];
	logic [SW-1:0] side_in [QW];
	logic          vld_in  [QW];
	logic [CW-1:0] sub_v   [QW];
	logic          take    [QW];

	always_comb begin
		rem_in[0]  = num;
		den_in[0]  = den;
		q_in[0]    = '0;
		side_in[0] = in_side;
		vld_in[0]  = in_vld;
		for (int k = 1; k < QW; k++) begin
			rem_in[k]  = rem_sn[k-1];
			den_in[k]  = den_sn[k-1];
			q_in[k]    = q_sn[k-1];
			side_in[k] = side_sn[k-1];
			vld_in[k]  = vld_sn[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			sub_v[k] = CW'(den_in[k]) << (QW - 1 - k);
			take[k]  = CW'(rem_in[k]) >= sub_v[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++)
				vld_sn[k] <= 1'b0;
		end else if (ce) begin
			for (int k = 0; k < QW; k++)
				vld_sn[k] <= vld_in[k];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int k = 0; k < QW; k++) begin
				rem_sn[k]  <= take[k] ? rem_in[k] - NW'(sub_v[k]) : rem_in[k];
				den_sn[k]  <= den_in[k];
				q_sn[k]    <= q_in[k] | (QW'(take[k]) << (QW - 1 - k));
				side_sn[k] <= side_in[k];
			end
		end
	end

	assign out_vld  = vld_sn[QW-1];
	assign quot     = q_sn[QW-1];
	assign out_side = side_sn[QW-1];

endmodule
